>>> design/score_sorted_box_suppression_macros.svh
`ifndef SCORE_SORTED_BOX_SUPPRESSION_MACROS_SVH
`define SCORE_SORTED_BOX_SUPPRESSION_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SBS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SBS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/sbs_pkg.sv
package sbs_pkg;

	localparam int MAX_BOXES  = 64;
	localparam int COORD_BITS = 16;
	localparam int IDX_W      = $clog2(MAX_BOXES);
	localparam int CNT_W      = $clog2(MAX_BOXES + 1);
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	localparam logic [15:0] COORD_MASK = 16'((64'd1 << COORD_BITS) - 64'd1);
	localparam logic [15:0] THR_RESET  = 16'd29491;

	typedef enum logic {
		REG_IOU_THR  = 1'b0,
		REG_AGNOSTIC = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [6:0]  label;
		logic [15:0] score;
		logic [15:0] left_x;
		logic [15:0] top_y;
		logic [15:0] right_x;
		logic [15:0] bottom_y;
		logic        last_box;
	} cand_t;

	typedef struct packed {
		logic [6:0]  kept_label;
		logic [15:0] kept_score;
		logic [15:0] kept_left;
		logic [15:0] kept_top;
		logic [15:0] kept_right;
		logic [15:0] kept_bottom;
		logic [5:0]  sorted_position;
		logic        overflowed;
		logic        last_kept;
	} kept_t;

	typedef struct packed {
		logic [6:0]  label;
		logic [15:0] score;
		logic [15:0] left_x;
		logic [15:0] top_y;
		logic [15:0] right_x;
		logic [15:0] bottom_y;
		logic [31:0] area;
	} box_t;

	typedef struct packed {
		box_t box;
		logic last;
	} qent_t;

	typedef struct packed {
		logic  valid;
		qent_t ent;
	} qout_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_RK_CUR,
		ST_RK_CURW,
		ST_RK_SCAN,
		ST_RK_CMP,
		ST_RK_WR,
		ST_SP_A,
		ST_SP_AW,
		ST_SP_B,
		ST_SP_I,
		ST_SP_U,
		ST_SP_C,
		ST_SP_WR,
		ST_EM_RD,
		ST_EM_WR
	} sbs_state_t;

	function automatic logic [15:0] span(input logic [15:0] lo, input logic [15:0] hi);
		return (hi > lo) ? hi - lo : 16'd0;
	endfunction

endpackage

>>> design/sbs_front.sv
module sbs_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  sbs_pkg::cand_t cand,
	input  logic          take,
	output sbs_pkg::qout_t qout
);
	import sbs_pkg::*;

	qent_t               mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_q, rd_q;
	logic [QCNT_W-1:0]   cnt_q;
	qent_t               ent;
	logic [15:0]         l, t, r, b;
	logic                wr_en, rd_en;

	always_comb begin
		l = cand.left_x & COORD_MASK;
		t = cand.top_y & COORD_MASK;
		r = cand.right_x & COORD_MASK;
		b = cand.bottom_y & COORD_MASK;
		ent.box.label    = cand.label;
		ent.box.score    = cand.score;
		ent.box.left_x   = l;
		ent.box.top_y    = t;
		ent.box.right_x  = r;
		ent.box.bottom_y = b;
		ent.box.area     = {16'd0, span(l, r)} * {16'd0, span(t, b)};
		ent.last         = cand.last_box;
	end

	assign full       = (cnt_q == QCNT_W'(QDEPTH));
	assign wr_en      = push && !full;
	assign qout.valid = (cnt_q != '0);
	assign qout.ent   = mem_q[rd_q];
	assign rd_en      = take && qout.valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_q] <= ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_q <= wr_q + 1'b1;
			end
			if (rd_en) begin
				rd_q <= rd_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> design/sbs_engine.sv
module sbs_engine (
	input  logic           clk,
	input  logic           arst_n,
	input  sbs_pkg::qout_t qout,
	output logic           take,
	input  logic [15:0]    thr,
	input  logic           agnostic,
	output logic           empty,
	input  logic           pop,
	output sbs_pkg::kept_t kept
);
	import sbs_pkg::*;

	sbs_state_t state_q, state_d;

	box_t             box_mem [MAX_BOXES];
	box_t             srt_mem [MAX_BOXES];
	logic             kept_mem [MAX_BOXES];
	box_t             box_rd_q, srt_rd_q;
	logic             kept_rd_q;

	logic [CNT_W-1:0] cnt_q, i_q, j_q;
	logic [IDX_W-1:0] rank_q, lastpos_q;
	logic             ovf_q, keep_q, rel_q, out_v_q;
	box_t             cur_q;
	logic [31:0]      inter_q;
	logic [48:0]      lhs_q, rhs_q;
	kept_t            out_q;

	logic             box_re, srt_re, kept_re, out_load;
	logic [IDX_W-1:0] box_ra, srt_ra;
	logic             room, i_last, j_last, hit, later;
	logic [15:0]      il, it, ir, ib;
	logic [32:0]      uni;

	assign room   = (cnt_q != CNT_W'(MAX_BOXES));
	assign i_last = (CNT_W'(i_q + 1'b1) == cnt_q);
	assign j_last = (CNT_W'(j_q + 1'b1) == i_q);
	assign hit    = rel_q && (lhs_q > rhs_q);
	// ties rank by arrival order
	assign later  = (box_rd_q.score > cur_q.score) ||
		((box_rd_q.score == cur_q.score) && (j_q < i_q));

	always_comb begin
		il  = (cur_q.left_x > srt_rd_q.left_x) ? cur_q.left_x : srt_rd_q.left_x;
		it  = (cur_q.top_y > srt_rd_q.top_y) ? cur_q.top_y : srt_rd_q.top_y;
		ir  = (cur_q.right_x < srt_rd_q.right_x) ? cur_q.right_x : srt_rd_q.right_x;
		ib  = (cur_q.bottom_y < srt_rd_q.bottom_y) ? cur_q.bottom_y : srt_rd_q.bottom_y;
		uni = {1'b0, cur_q.area} + {1'b0, srt_rd_q.area} - {1'b0, inter_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		take     = 1'b0;
		box_re   = 1'b0;
		srt_re   = 1'b0;
		kept_re  = 1'b0;
		box_ra   = j_q[IDX_W-1:0];
		srt_ra   = j_q[IDX_W-1:0];
		out_load = 1'b0;
		case (state_q)
			ST_LOAD: begin
				take = qout.valid;
				if (qout.valid && qout.ent.last) begin
					state_d = ST_RK_CUR;
				end
			end
			ST_RK_CUR: begin
				box_re  = 1'b1;
				box_ra  = i_q[IDX_W-1:0];
				state_d = ST_RK_CURW;
			end
			ST_RK_CURW: state_d = ST_RK_SCAN;
			ST_RK_SCAN: begin
				box_re  = 1'b1;
				state_d = ST_RK_CMP;
			end
			ST_RK_CMP: begin
				state_d = (CNT_W'(j_q + 1'b1) == cnt_q) ? ST_RK_WR : ST_RK_SCAN;
			end
			ST_RK_WR: state_d = i_last ? ST_SP_A : ST_RK_CUR;
			ST_SP_A: begin
				srt_re  = 1'b1;
				srt_ra  = i_q[IDX_W-1:0];
				state_d = ST_SP_AW;
			end
			ST_SP_AW: state_d = (i_q == '0) ? ST_SP_WR : ST_SP_B;
			ST_SP_B: begin
				srt_re  = 1'b1;
				kept_re = 1'b1;
				state_d = ST_SP_I;
			end
			ST_SP_I: state_d = ST_SP_U;
			ST_SP_U: state_d = ST_SP_C;
			ST_SP_C: state_d = (hit || j_last) ? ST_SP_WR : ST_SP_B;
			ST_SP_WR: state_d = i_last ? ST_EM_RD : ST_SP_A;
			ST_EM_RD: begin
				srt_re  = 1'b1;
				kept_re = 1'b1;
				srt_ra  = i_q[IDX_W-1:0];
				state_d = ST_EM_WR;
			end
			ST_EM_WR: begin
				if (!kept_rd_q || !out_v_q || pop) begin
					out_load = kept_rd_q;
					state_d  = i_last ? ST_LOAD : ST_EM_RD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && qout.valid && room) begin
			box_mem[cnt_q[IDX_W-1:0]] <= qout.ent.box;
		end
		if (box_re) begin
			box_rd_q <= box_mem[box_ra];
		end
		if (state_q == ST_RK_WR) begin
			srt_mem[rank_q] <= cur_q;
		end
		if (srt_re) begin
			srt_rd_q <= srt_mem[srt_ra];
		end
		if (state_q == ST_SP_WR) begin
			kept_mem[i_q[IDX_W-1:0]] <= keep_q;
		end
		if (kept_re) begin
			kept_rd_q <= kept_mem[srt_ra];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_RK_CURW: cur_q <= box_rd_q;
			ST_SP_AW:   cur_q <= srt_rd_q;
			ST_SP_I: begin
				inter_q <= {16'd0, span(il, ir)} * {16'd0, span(it, ib)};
				rel_q   <= kept_rd_q && (agnostic || (cur_q.label == srt_rd_q.label));
			end
			ST_SP_U: begin
				lhs_q <= {1'b0, inter_q, 16'd0};
				rhs_q <= {33'd0, thr} * {16'd0, uni};
			end
			default: ;
		endcase
		if (out_load) begin
			out_q.kept_label      <= srt_rd_q.label;
			out_q.kept_score      <= srt_rd_q.score;
			out_q.kept_left       <= srt_rd_q.left_x;
			out_q.kept_top        <= srt_rd_q.top_y;
			out_q.kept_right      <= srt_rd_q.right_x;
			out_q.kept_bottom     <= srt_rd_q.bottom_y;
			out_q.sorted_position <= 6'(i_q);
			out_q.overflowed      <= ovf_q;
			out_q.last_kept       <= (i_q[IDX_W-1:0] == lastpos_q);
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			rank_q    <= '0;
			keep_q    <= 1'b0;
			lastpos_q <= '0;
			out_v_q   <= 1'b0;
		end else begin
			if (pop && out_v_q) begin
				out_v_q <= 1'b0;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end
			case (state_q)
				ST_LOAD: begin
					i_q <= '0;
					if (qout.valid) begin
						if (room) begin
							cnt_q <= cnt_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				ST_RK_CURW: begin
					j_q    <= '0;
					rank_q <= '0;
				end
				ST_RK_CMP: begin
					if ((j_q != i_q) && later) begin
						rank_q <= rank_q + 1'b1;
					end
					j_q <= j_q + 1'b1;
				end
				ST_RK_WR: i_q <= i_last ? '0 : i_q + 1'b1;
				ST_SP_AW: begin
					keep_q <= 1'b1;
					j_q    <= '0;
				end
				ST_SP_C: begin
					if (hit) begin
						keep_q <= 1'b0;
					end
					j_q <= j_q + 1'b1;
				end
				ST_SP_WR: begin
					if (keep_q) begin
						lastpos_q <= i_q[IDX_W-1:0];
					end
					i_q <= i_last ? '0 : i_q + 1'b1;
				end
				ST_EM_WR: begin
					if (!kept_rd_q || !out_v_q || pop) begin
						if (i_last) begin
							cnt_q <= '0;
							ovf_q <= 1'b0;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign empty = !out_v_q;
	assign kept  = out_q;

endmodule

>>> design/score_sorted_box_suppression.sv
// channel   | handshake          | payload
// ----------+--------------------+-------------------------------
// candidate | push / full        | cand  (label, score, corners, last_box)
// result    | pop / empty        | kept  (kept box, rank, flags)
// config    | cfg_wen            | cfg_index, cfg_data
//
// A 4-deep front queue takes one candidate per cycle while not full; the back
// engine drains it into box memory, one per cycle while loading. On last_box it
// ranks n boxes (n+1 single-port reads per box), runs suppression (stops on the
// first hit against an earlier box) and walks the sorted boxes, emitting the
// kept ones; new candidates queue in front meanwhile.
// Results stall in the output register while pop is low.
// arst_n clears control state and loads the register defaults.
module score_sorted_box_suppression (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  sbs_pkg::cand_t cand,
	output logic           empty,
	input  logic           pop,
	output sbs_pkg::kept_t kept,
	input  logic           cfg_wen,
	input  logic           cfg_index,
	input  logic [15:0]    cfg_data
);
	import sbs_pkg::*;

	logic [15:0] thr_q;
	logic        agn_q;
	qout_t       qout;
	logic        take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
			agn_q <= 1'b0;
		end else if (cfg_wen) begin
			case (reg_idx_t'(cfg_index))
				REG_IOU_THR:  thr_q <= cfg_data;
				REG_AGNOSTIC: agn_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	sbs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.cand   (cand),
		.take   (take),
		.qout   (qout)
	);

	sbs_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.qout     (qout),
		.take     (take),
		.thr      (thr_q),
		.agnostic (agn_q),
		.empty    (empty),
		.pop      (pop),
		.kept     (kept)
	);

endmodule

>>> design/sbs_checker.sv
`include "score_sorted_box_suppression_macros.svh"

module sbs_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           empty,
	input logic           pop,
	input sbs_pkg::kept_t kept
);

	`SBS_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(kept), "result changed while stalled")
	`SBS_ASSERT_NEXT(a_rank, pop && !empty && !kept.last_kept, empty || (kept.sorted_position > $past(kept.sorted_position)), "rank not rising within a set")
	`SBS_ASSERT_NEXT(a_score, pop && !empty && !kept.last_kept, empty || (kept.kept_score <= $past(kept.kept_score)), "score order broken within a set")
	`SBS_ASSERT_NEXT(a_ovf, pop && !empty && !kept.last_kept, empty || (kept.overflowed == $past(kept.overflowed)), "overflow flag changed within a set")

endmodule

bind score_sorted_box_suppression sbs_checker u_sbs_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.kept   (kept)
);

>>> test/score_sorted_box_suppression_check.sv
module score_sorted_box_suppression_check (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  logic           full,
	input  sbs_pkg::cand_t cand,
	input  logic           empty,
	input  logic           pop,
	input  sbs_pkg::kept_t kept,
	input  logic           cfg_wen,
	input  logic           cfg_index,
	input  logic [15:0]    cfg_data,
	output int             fails,
	output int             pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import sbs_pkg::*;

	logic [15:0] thr;
	logic        agnostic;
	cand_t       set_box [MAX_BOXES];
	int          set_n;
	logic        set_ovf;
	kept_t       kept_fifo [$];

	function automatic logic [31:0] box_area(cand_t b);
		logic [15:0] w, h;
		w = (b.right_x > b.left_x) ? b.right_x - b.left_x : 16'd0;
		h = (b.bottom_y > b.top_y) ? b.bottom_y - b.top_y : 16'd0;
		return 32'(w) * 32'(h);
	endfunction

	// exact overlap test: inter * 65536 > thr * union
	function automatic bit overlap_hit(cand_t a, cand_t b);
		logic [15:0] l, t, r, d, w, h;
		longint unsigned inter, uni;
		l = (a.left_x > b.left_x) ? a.left_x : b.left_x;
		t = (a.top_y > b.top_y) ? a.top_y : b.top_y;
		r = (a.right_x < b.right_x) ? a.right_x : b.right_x;
		d = (a.bottom_y < b.bottom_y) ? a.bottom_y : b.bottom_y;
		w = (r > l) ? r - l : 16'd0;
		h = (d > t) ? d - t : 16'd0;
		inter = longint'(w) * longint'(h);
		uni = longint'(box_area(a)) + longint'(box_area(b)) - inter;
		return (inter << 16) > longint'(thr) * uni;
	endfunction

	task automatic predict_kept();
		int    rank [MAX_BOXES];
		bit    keep_f [MAX_BOXES];
		int    p, a, b, lastpos;
		bit    keep;
		kept_t k;
		lastpos = -1;
		for (int i = 0; i < set_n; i++) begin
			p = i;
			while (p > 0 && set_box[rank[p-1]].score < set_box[i].score) begin
				rank[p] = rank[p-1];
				p--;
			end
			rank[p] = i;
		end
		for (int i = 0; i < set_n; i++) begin
			a = rank[i];
			keep = 1;
			for (int j = 0; j < i && keep; j++) begin
				b = rank[j];
				if (!keep_f[b]) continue;
				if (!agnostic && set_box[a].label != set_box[b].label) continue;
				if (overlap_hit(set_box[a], set_box[b])) keep = 0;
			end
			keep_f[a] = keep;
			if (keep) lastpos = i;
		end
		for (int i = 0; i < set_n; i++) begin
			a = rank[i];
			if (!keep_f[a]) continue;
			k.kept_label      = set_box[a].label;
			k.kept_score      = set_box[a].score;
			k.kept_left       = set_box[a].left_x;
			k.kept_top        = set_box[a].top_y;
			k.kept_right      = set_box[a].right_x;
			k.kept_bottom     = set_box[a].bottom_y;
			k.sorted_position = 6'(i);
			k.overflowed      = set_ovf;
			k.last_kept       = (i == lastpos);
			kept_fifo.insert(kept_fifo.size(), k);
		end
		set_n = 0;
		set_ovf = 0;
	endtask

	task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endtask

	initial begin
		fails = 0;
		pending = 0;
		thr = THR_RESET;
		agnostic = 0;
		set_n = 0;
		set_ovf = 0;
	end

	always @(posedge clk) begin
		kept_t want;
		if (arst_n) begin
			if (cfg_wen) begin
				if (reg_idx_t'(cfg_index) == REG_IOU_THR) thr = cfg_data;
				else agnostic = cfg_data[0];
			end
			if (pop && !empty) begin
				if (kept_fifo.size() == 0) begin
					$error("result transfer with nothing expected: %p", kept);
					fails++;
				end else begin
					want = kept_fifo.pop_front();
					compare_field("kept_label", want.kept_label, kept.kept_label);
					compare_field("kept_score", want.kept_score, kept.kept_score);
					compare_field("kept_left", want.kept_left, kept.kept_left);
					compare_field("kept_top", want.kept_top, kept.kept_top);
					compare_field("kept_right", want.kept_right, kept.kept_right);
					compare_field("kept_bottom", want.kept_bottom, kept.kept_bottom);
					compare_field("sorted_position", want.sorted_position,
						kept.sorted_position);
					compare_field("overflowed", want.overflowed, kept.overflowed);
					compare_field("last_kept", want.last_kept, kept.last_kept);
				end
			end
			if (push && !full) begin
				if (set_n < MAX_BOXES) begin
					set_box[set_n] = cand;
					set_box[set_n].last_box = 0;
					set_n++;
				end else
					set_ovf = 1;
				if (cand.last_box) predict_kept();
			end
			pending = kept_fifo.size();
		end
	end
endmodule

>>> test/score_sorted_box_suppression_test.sv
module score_sorted_box_suppression_test;
	timeunit 1ns;
	timeprecision 1ps;
	import sbs_pkg::*;

	localparam int STALL_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 400;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        push = 0;
	logic        full;
	cand_t       cand = '0;
	logic        empty;
	logic        pop = 0;
	kept_t       kept;
	logic        cfg_wen = 0;
	logic        cfg_index = 0;
	logic [15:0] cfg_data = '0;
	int          fails, pending;
	int          send_idle_pct = 0, stall_pct = 0;
	int          quiet_cycles = 0;
	int          sent;

	always #2 clk = ~clk;

	score_sorted_box_suppression dut (.*);

	score_sorted_box_suppression_check checker_i (.*);

	always @(posedge clk) begin
		if (arst_n) pop <= ($urandom_range(99) >= stall_pct);
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL score_sorted_box_suppression");
			$finish;
		end
	end

	task automatic send_box(cand_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 0;
			@(posedge clk);
		end
		push <= 1;
		cand <= c;
		@(posedge clk);
		while (full) @(posedge clk);
		sent++;
	endtask

	function automatic cand_t make_box(logic [6:0] lbl, logic [15:0] sc,
		logic [15:0] l, logic [15:0] t, logic [15:0] r, logic [15:0] b, logic lst);
		cand_t c;
		c.label = lbl; c.score = sc; c.left_x = l; c.top_y = t;
		c.right_x = r; c.bottom_y = b; c.last_box = lst;
		return c;
	endfunction

	// boxes jittered around a few anchors so that overlaps and ties are common
	function automatic cand_t rand_box(logic lst);
		cand_t c;
		int cx, cy, hw, hh;
		if ($urandom_range(9) == 0) begin
			c = cand_t'(88'({$urandom, $urandom, $urandom}));
		end else begin
			cx = 4000 + $urandom_range(3) * 12000 + $urandom_range(600);
			cy = 4000 + $urandom_range(3) * 12000 + $urandom_range(600);
			hw = 200 + $urandom_range(2000);
			hh = 200 + $urandom_range(2000);
			c.label = ($urandom_range(9) == 0) ? 7'($urandom_range(127))
				: 7'($urandom_range(2));
			c.score = ($urandom_range(3) == 0) ? 16'($urandom_range(3) * 1000)
				: 16'($urandom);
			c.left_x = 16'(cx - hw);
			c.top_y = 16'(cy - hh);
			c.right_x = 16'(cx + hw);
			c.bottom_y = 16'(cy + hh);
			if ($urandom_range(19) == 0) begin
				c.left_x = 16'(cx + hw);
				c.right_x = 16'(cx - hw);
			end
		end
		c.last_box = lst;
		return c;
	endfunction

	task automatic send_set();
		int n, pick;
		pick = $urandom_range(99);
		if (pick < 85) n = $urandom_range(8, 1);
		else if (pick < 96) n = $urandom_range(20, 9);
		else n = $urandom_range(67, 63);
		for (int i = 0; i < n; i++) send_box(rand_box(i == n - 1));
	endtask

	task automatic write_reg(reg_idx_t idx, logic [15:0] val);
		cfg_wen <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// wait for the block to go idle, then reconfigure
	task automatic next_phase(logic [15:0] t, logic ag, int idle_pct, int stall);
		push <= 0;
		// let the checker see the final transfer before looking at pending
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_reg(REG_IOU_THR, t);
		write_reg(REG_AGNOSTIC, 16'(ag));
		cfg_wen <= 0;
		send_idle_pct = idle_pct;
		stall_pct = stall;
	endtask

	task automatic run_random(int count);
		int goal;
		goal = sent + count;
		while (sent < goal) send_set();
	endtask

	initial begin
		sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// lone zero box, then extremes, ties, inverted corners, zero union
		send_box(make_box(7'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1));
		send_box(make_box(7'h7f, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b0));
		send_box(make_box(7'd3, 16'd500, 16'd100, 16'd100, 16'd900, 16'd900, 1'b0));
		send_box(make_box(7'd3, 16'd500, 16'd110, 16'd110, 16'd910, 16'd910, 1'b0));
		send_box(make_box(7'd4, 16'd500, 16'd100, 16'd100, 16'd900, 16'd900, 1'b0));
		send_box(make_box(7'd3, 16'd700, 16'd900, 16'd900, 16'd100, 16'd100, 1'b0));
		send_box(make_box(7'd79, 16'd65534, 16'd0, 16'd0, 16'hffff, 16'hffff, 1'b0));
		send_box(make_box(7'd79, 16'd1, 16'd0, 16'd0, 16'hffff, 16'hffff, 1'b1));
		send_box(make_box(7'd5, 16'd9, 16'd50, 16'd50, 16'd50, 16'd50, 1'b0));
		send_box(make_box(7'd5, 16'd8, 16'd50, 16'd50, 16'd50, 16'd50, 1'b0));
		send_box(make_box(7'd80, 16'd8, 16'd0, 16'd0, 16'd64, 16'd64, 1'b0));
		send_box(make_box(7'd80, 16'd8, 16'd0, 16'd0, 16'd64, 16'd64, 1'b1));
		run_random(100);

		next_phase(16'd0, 1'b1, 46, 0);
		run_random(100);
		next_phase(16'hffff, 1'b0, 0, 46);
		run_random(100);
		next_phase(16'($urandom_range(50000, 10000)), 1'b1, 37, 37);
		run_random(100);

		push <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("PASS score_sorted_box_suppression");
		else
			$display("FAIL score_sorted_box_suppression");
		$finish;
	end
endmodule

>>> filelist.f
+incdir+design
design/sbs_pkg.sv
design/sbs_front.sv
design/sbs_engine.sv
design/score_sorted_box_suppression.sv
design/sbs_checker.sv
test/score_sorted_box_suppression_check.sv
test/score_sorted_box_suppression_test.sv
